[hdl/wep_pkg.sv]
package wep_pkg;

	localparam int unsigned MODE_W    = 1;
	localparam int unsigned WEIGHT_W  = 32;
	localparam int unsigned FRAC_W    = 32;
	localparam int unsigned PIDX_W    = 10;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned MUL_W     = 2 * FRAC_W;

	localparam logic [MODE_W-1:0] MODE_ADD  = 1'b0;
	localparam logic [MODE_W-1:0] MODE_PICK = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_NONE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_LO,
		S_MUL_HI,
		S_SCAN,
		S_RESULT
	} state_t;

endpackage

[hdl/wep_ifs.sv]
interface wep_req_if;
	logic                            valid;
	logic                            ready;
	logic [wep_pkg::MODE_W-1:0]      mode;
	logic [wep_pkg::WEIGHT_W-1:0]    weight;
	logic [wep_pkg::FRAC_W-1:0]      rand_fraction;

	modport source (output valid, output mode, output weight, output rand_fraction,
		input ready);
	modport sink (input valid, input mode, input weight, input rand_fraction,
		output ready);
endinterface

interface wep_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [wep_pkg::PIDX_W-1:0]      picked_index;
	wep_pkg::status_t                status;

	modport source (output valid, output picked_index, output status, input ready);
	modport sink (input valid, input picked_index, input status, output ready);
endinterface

[hdl/weighted_entry_picker_unit.sv]
// Roulette-wheel picker over a table of up to DEPTH weights. An add word (mode 0) appends its
// weight and returns the new index, or status full. A pick word (mode 1) forms
// (rand_fraction * total) >> 32 with one shared 32x32 multiplier, used for the low and then
// the high half of the total, then walks the weight memory through its single registered
// read port, one entry per cycle, until the running sum exceeds the scaled value or the
// last entry is read. Picks on an empty or one-entry table skip the multiply and the walk.
// The result sits in an output register, and the block takes no new word until the previous
// result has moved into it.
module weighted_entry_picker_unit #(
	parameter int unsigned DEPTH       = 1024,
	parameter int unsigned WEIGHT_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	wep_req_if.sink       req,
	wep_rsp_if.source     rsp
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned TB = WEIGHT_BITS + AW;
	localparam int unsigned HW = wep_pkg::FRAC_W;

	wep_pkg::state_t state_q, state_d;

	logic [WEIGHT_BITS-1:0] mem [DEPTH];

	logic [CW-1:0]                 count_q;
	logic [TB-1:0]                 total_q;
	logic [HW-1:0]                 rand_q;
	logic [wep_pkg::MUL_W-1:0]     mul_q;
	logic [TB-1:0]                 scaled_q;
	logic [TB-1:0]                 acc_q;
	logic [CW-1:0]                 iss_q;
	logic                          rv_s1;
	logic [AW-1:0]                 ridx_s1;
	logic [WEIGHT_BITS-1:0]        rdata_s1;
	logic [wep_pkg::PIDX_W-1:0]    res_idx_q;
	wep_pkg::status_t              res_st_q;
	logic                          ovalid_q;
	logic [wep_pkg::PIDX_W-1:0]    oidx_q;
	wep_pkg::status_t              ost_q;

	logic                          accept;
	logic                          is_add;
	logic                          is_full;
	logic                          wr_en;
	logic [WEIGHT_BITS-1:0]        w_in;
	logic [AW-1:0]                 rd_addr;
	logic [wep_pkg::MUL_W-1:0]     total_ext;
	logic [HW-1:0]                 mul_b;
	logic [wep_pkg::MUL_W-1:0]     mul_p;
	logic [TB-1:0]                 sum;
	logic                          hit;
	logic                          last;
	logic                          out_free;

	assign accept    = req.valid && req.ready;
	assign is_add    = (req.mode == wep_pkg::MODE_ADD);
	assign is_full   = (count_q == CW'(DEPTH));
	assign wr_en     = accept && is_add && !is_full;
	assign w_in      = WEIGHT_BITS'(req.weight);
	assign rd_addr   = iss_q[AW-1:0];
	assign total_ext = wep_pkg::MUL_W'(total_q);
	assign mul_b     = (state_q == wep_pkg::S_MUL_HI) ? total_ext[wep_pkg::MUL_W-1:HW]
		: total_ext[HW-1:0];
	assign mul_p     = rand_q * mul_b;
	assign sum       = acc_q + TB'(rdata_s1);
	assign hit       = (scaled_q < sum);
	assign last      = (CW'(ridx_s1) == (count_q - CW'(1)));
	assign out_free  = !ovalid_q || rsp.ready;

	// weight memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= w_in;
		end
		rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wep_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		unique case (state_q)
			wep_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (accept) begin
					if (is_add || (count_q <= CW'(1))) begin
						state_d = wep_pkg::S_RESULT;
					end else begin
						state_d = wep_pkg::S_MUL_LO;
					end
				end
			end
			wep_pkg::S_MUL_LO: state_d = wep_pkg::S_MUL_HI;
			wep_pkg::S_MUL_HI: state_d = wep_pkg::S_SCAN;
			wep_pkg::S_SCAN: begin
				if (rv_s1 && (hit || last)) begin
					state_d = wep_pkg::S_RESULT;
				end
			end
			wep_pkg::S_RESULT: begin
				if (out_free) begin
					state_d = wep_pkg::S_IDLE;
				end
			end
			default: state_d = wep_pkg::S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			total_q  <= '0;
			iss_q    <= '0;
			rv_s1    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				count_q <= count_q + CW'(1);
				total_q <= total_q + TB'(w_in);
			end
			if (accept) begin
				iss_q <= '0;
				rv_s1 <= 1'b0;
			end else if (state_q == wep_pkg::S_SCAN) begin
				// issue one read per cycle until the last entry
				if (iss_q < count_q) begin
					iss_q <= iss_q + CW'(1);
					rv_s1 <= 1'b1;
				end else begin
					rv_s1 <= 1'b0;
				end
			end
			if ((state_q == wep_pkg::S_RESULT) && out_free) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			rand_q <= req.rand_fraction;
			acc_q  <= '0;
			if (is_add) begin
				res_idx_q <= is_full ? '0 : wep_pkg::PIDX_W'(count_q);
				res_st_q  <= is_full ? wep_pkg::ST_FULL : wep_pkg::ST_OK;
			end else begin
				res_idx_q <= '0;
				res_st_q  <= (count_q == '0) ? wep_pkg::ST_NONE : wep_pkg::ST_OK;
			end
		end
		if (state_q == wep_pkg::S_MUL_LO) begin
			mul_q <= mul_p;
		end
		if (state_q == wep_pkg::S_MUL_HI) begin
			scaled_q <= TB'(mul_q[wep_pkg::MUL_W-1:HW]);
			mul_q    <= mul_p;
		end
		if (state_q == wep_pkg::S_SCAN) begin
			// fold in the high partial product before the first compare
			if (iss_q == '0) begin
				scaled_q <= scaled_q + TB'(mul_q);
			end
			if (iss_q < count_q) begin
				ridx_s1 <= rd_addr;
			end
			if (rv_s1) begin
				acc_q <= sum;
				if (hit) begin
					res_idx_q <= wep_pkg::PIDX_W'(ridx_s1);
					res_st_q  <= wep_pkg::ST_OK;
				end else if (last) begin
					res_idx_q <= '0;
					res_st_q  <= wep_pkg::ST_NONE;
				end
			end
		end
		if ((state_q == wep_pkg::S_RESULT) && out_free) begin
			oidx_q <= res_idx_q;
			ost_q  <= res_st_q;
		end
	end

	assign rsp.valid        = ovalid_q;
	assign rsp.picked_index = oidx_q;
	assign rsp.status       = ost_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond table depth");

	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (total_q == '0))
		else $error("nonzero total with an empty table");

	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (count_q == $past(count_q) + CW'(1)))
		else $error("add did not advance entry count");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == wep_pkg::S_SCAN) && rv_s1) |-> (CW'(ridx_s1) < count_q))
		else $error("scan read past the last entry");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != wep_pkg::S_IDLE) |-> !req.ready)
		else $error("ready while a word is in progress");

endmodule

[tb/sv/weighted_entry_picker_unit_test.sv]
`timescale 1ns / 100ps

module weighted_entry_picker_unit_test;

	localparam int unsigned MODE_W         = wep_pkg::MODE_W;
	localparam int unsigned WEIGHT_W       = wep_pkg::WEIGHT_W;
	localparam int unsigned FRAC_W         = wep_pkg::FRAC_W;
	localparam int unsigned PIDX_W         = wep_pkg::PIDX_W;
	localparam int unsigned TABLE_DEPTH    = 1024;
	localparam int unsigned SUM_W          = 42;
	localparam int unsigned PROD_W         = FRAC_W + SUM_W;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int unsigned REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [PIDX_W-1:0] index;
		wep_pkg::status_t  status;
	} pick_result_t;

	logic clk;
	logic arst_n;

	wep_req_if req_bus ();
	wep_rsp_if rsp_bus ();

	weighted_entry_picker_unit #(
		.DEPTH(TABLE_DEPTH),
		.WEIGHT_BITS(WEIGHT_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	// Predictor state: the weights appended so far and their running total
	logic [WEIGHT_W-1:0] table_weights [TABLE_DEPTH];
	int unsigned         entry_total;
	logic [SUM_W-1:0]    weight_sum;

	pick_result_t pending_results [$];

	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;
	int unsigned mismatch_count;
	int unsigned idle_cycles;
	int unsigned add_words;
	int unsigned pick_words;
	int unsigned ok_seen;
	int unsigned full_seen;
	int unsigned none_seen;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic pick_result_t apply_word(input logic [MODE_W-1:0] mode,
		input logic [WEIGHT_W-1:0] weight, input logic [FRAC_W-1:0] frac);
		pick_result_t      res;
		logic [PROD_W-1:0] product;
		logic [SUM_W-1:0]  scaled;
		logic [SUM_W-1:0]  running;
		int unsigned       i;
		res.index  = '0;
		res.status = wep_pkg::ST_NONE;
		if (mode == wep_pkg::MODE_ADD) begin
			if (entry_total >= TABLE_DEPTH) begin
				res.status = wep_pkg::ST_FULL;
			end else begin
				table_weights[entry_total] = weight;
				weight_sum   = weight_sum + SUM_W'(weight);
				res.index    = entry_total[PIDX_W-1:0];
				res.status   = wep_pkg::ST_OK;
				entry_total  = entry_total + 1;
			end
		end else if (entry_total == 1) begin
			res.status = wep_pkg::ST_OK;
		end else if (entry_total > 1) begin
			product = PROD_W'(frac) * PROD_W'(weight_sum);
			scaled  = product[PROD_W-1:FRAC_W];
			running = '0;
			// first entry whose running sum exceeds the scaled draw
			for (i = 0; i < entry_total && res.status != wep_pkg::ST_OK; i++) begin
				running = running + SUM_W'(table_weights[i]);
				if (scaled < running) begin
					res.index  = i[PIDX_W-1:0];
					res.status = wep_pkg::ST_OK;
				end
			end
		end
		return res;
	endfunction

	function automatic logic [WEIGHT_W-1:0] random_weight();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2, 3: return WEIGHT_W'($urandom_range(255));
			default: return WEIGHT_W'($urandom);
		endcase
	endfunction

	function automatic logic [FRAC_W-1:0] random_frac();
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			default: return FRAC_W'($urandom);
		endcase
	endfunction

	// Keep valid high across back-to-back words; drop it only for an idle gap
	task automatic send_word(input logic [MODE_W-1:0] mode, input logic [WEIGHT_W-1:0] weight,
		input logic [FRAC_W-1:0] frac);
		pick_result_t expected;
		while ($urandom_range(99) < src_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid         <= 1'b1;
		req_bus.mode          <= mode;
		req_bus.weight        <= weight;
		req_bus.rand_fraction <= frac;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		expected        = apply_word(mode, weight, frac);
		pending_results = {pending_results, expected};
		if (mode == wep_pkg::MODE_ADD) add_words++;
		else pick_words++;
	endtask

	task automatic drain_results();
		req_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_table();
		send_word(wep_pkg::MODE_PICK, '0, '0);
		send_word(wep_pkg::MODE_PICK, '1, '1);
		send_word(wep_pkg::MODE_ADD, '0, '1);
		// one entry of zero weight is still picked
		send_word(wep_pkg::MODE_PICK, WEIGHT_W'($urandom), '1);
		send_word(wep_pkg::MODE_PICK, '0, '0);
	endtask

	task automatic test_zero_weights();
		send_word(wep_pkg::MODE_ADD, '0, FRAC_W'($urandom));
		send_word(wep_pkg::MODE_PICK, '0, '0);
		send_word(wep_pkg::MODE_PICK, '1, '1);
		send_word(wep_pkg::MODE_PICK, '0, 32'h8000_0000);
	endtask

	task automatic test_extreme_weights();
		send_word(wep_pkg::MODE_ADD, '1, '0);
		send_word(wep_pkg::MODE_ADD, 32'd1, '0);
		send_word(wep_pkg::MODE_PICK, '0, '0);
		// scaled draw lands exactly on a running sum: must move to the next entry
		send_word(wep_pkg::MODE_PICK, '0, '1);
		send_word(wep_pkg::MODE_PICK, '1, 32'h8000_0000);
		send_word(wep_pkg::MODE_ADD, 32'h8000_0000, 32'h5555_5555);
		send_word(wep_pkg::MODE_ADD, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
		send_word(wep_pkg::MODE_PICK, 32'h5555_5555, 32'h7FFF_FFFF);
		send_word(wep_pkg::MODE_PICK, 32'hAAAA_AAAA, 32'hFFFF_FFFE);
		send_word(wep_pkg::MODE_PICK, '0, 32'h0000_0001);
	endtask

	task automatic test_random_traffic(input int unsigned words, input int unsigned src_pct,
		input int unsigned snk_pct);
		int unsigned n;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		for (n = 0; n < words; n++) begin
			if ($urandom_range(9) < 3) begin
				send_word(wep_pkg::MODE_ADD, random_weight(), FRAC_W'($urandom));
			end else begin
				send_word(wep_pkg::MODE_PICK, WEIGHT_W'($urandom), random_frac());
			end
		end
		drain_results();
	endtask

	task automatic test_table_full();
		int unsigned n;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		while (entry_total < TABLE_DEPTH) begin
			send_word(wep_pkg::MODE_ADD, random_weight(), FRAC_W'($urandom));
		end
		for (n = 0; n < 3; n++) begin
			send_word(wep_pkg::MODE_ADD, random_weight(), FRAC_W'($urandom));
		end
		send_word(wep_pkg::MODE_PICK, '0, '1);
		send_word(wep_pkg::MODE_PICK, '1, '0);
		for (n = 0; n < 4; n++) begin
			send_word(wep_pkg::MODE_PICK, WEIGHT_W'($urandom), FRAC_W'($urandom));
		end
		snk_idle_pct = 60;
		send_word(wep_pkg::MODE_ADD, '1, '1);
		send_word(wep_pkg::MODE_PICK, '0, random_frac());
		drain_results();
	endtask

	always @(posedge clk) begin
		pick_result_t want;
		if (arst_n) begin
			idle_cycles++;
			if (req_bus.valid && req_bus.ready) idle_cycles = 0;
			if (rsp_bus.valid && rsp_bus.ready) begin
				idle_cycles = 0;
				case (rsp_bus.status)
					wep_pkg::ST_OK: ok_seen++;
					wep_pkg::ST_FULL: full_seen++;
					default: none_seen++;
				endcase
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected result: index %0d status %0d",
							rsp_bus.picked_index, rsp_bus.status);
				end else begin
					want = pending_results.pop_front();
					if (rsp_bus.picked_index !== want.index
						|| rsp_bus.status !== want.status) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display({"result mismatch at %0t: index exp %0d got %0d,",
								" status exp %0d got %0d"},
								$realtime, want.index, rsp_bus.picked_index, want.status,
								rsp_bus.status);
					end
				end
			end
		end
		rsp_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", idle_cycles);
			$display("weighted_entry_picker_unit_test: errors");
			$finish;
		end
	end

	initial begin
		entry_total           = 0;
		weight_sum            = '0;
		mismatch_count        = 0;
		idle_cycles           = 0;
		add_words             = 0;
		pick_words            = 0;
		ok_seen               = 0;
		full_seen             = 0;
		none_seen             = 0;
		src_idle_pct          = 0;
		snk_idle_pct          = 0;
		arst_n                = 1'b0;
		req_bus.valid         <= 1'b0;
		req_bus.mode          <= wep_pkg::MODE_ADD;
		req_bus.weight        <= '0;
		req_bus.rand_fraction <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_zero_weights();
		test_extreme_weights();
		drain_results();
		test_random_traffic(190, 16, 60);
		test_random_traffic(190, 60, 16);
		test_random_traffic(190, 0, 0);
		test_table_full();

		repeat (20) @(posedge clk);
		$display("covered %0d add words and %0d pick words, table filled to %0d entries",
			add_words, pick_words, entry_total);
		$display("results seen: %0d ok, %0d table full, %0d nothing selectable; %0d mismatches",
			ok_seen, full_seen, none_seen, mismatch_count);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("weighted_entry_picker_unit_test: clean");
		end else begin
			$display("weighted_entry_picker_unit_test: errors");
		end
		$finish;
	end

endmodule
